[hw/rtl/ddwr_pkg.sv]
package ddwr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WHEEL_DIAMETER = 2'd0;
  localparam logic [1:0] CFG_TRACK_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_GEAR_RATIO     = 2'd2;
  localparam logic [1:0] CFG_MAX_RPM        = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_WHEEL_DIAMETER = 16'd1024;
  localparam logic [15:0] RST_TRACK_WIDTH    = 16'd3072;
  localparam logic [15:0] RST_GEAR_RATIO     = 16'd256;
  localparam logic [15:0] RST_MAX_RPM        = 16'd3200;

  // Curve direction codes.
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  // Fixed-point scale factors of the kinematics.
  localparam logic signed [23:0] K_BASE  = 24'sd5120000;
  localparam logic signed [8:0]  K_TURN  = 9'sd254;
  localparam logic [18:0]        K_DEN   = 19'd392699;
  localparam logic signed [9:0]  K_NUM   = 10'sd375;

  // Datapath widths.
  localparam int NumW  = 49;  // signed side numerator after the 375 factor
  localparam int DenW  = 51;  // unsigned common denominator
  localparam int Quo0W = 30;  // magnitude bits of the first quotient
  localparam int ValW  = 32;  // signed side value after the first division

  // Saturation bounds of the result fields.
  localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
  localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

endpackage

[hw/rtl/diff_drive_wheel_rpm.sv]
// Differential drive inverse kinematics: each chassis command (linear and
// angular velocity, curve direction) becomes one pair of signed Q20.4 motor
// RPM values. The block takes one command per clock cycle while its output
// is not stalled. Most of its depth is three bit-per-stage divider
// pipelines (the side RPM division, then the left and the right overspeed
// scaling), each resolving one quotient bit per stage.
// The pipeline advances whenever the output register is empty or being
// read, so a stalled output holds every command in flight without loss.
// Configuration registers must only be written while no command is in
// flight.
module diff_drive_wheel_rpm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] linear_velocity, [31:16] angular_velocity,
  // [33:32] curve_direction, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] left_rpm, [47:24] right_rpm
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int VW = ddwr_pkg::ValW;

  logic [15:0] diameter_q, track_q, gear_q, max_q;
  logic        out_vld_q;
  logic [23:0] left_out_q, right_out_q;

  logic en;
  logic f_vld;
  logic signed [ddwr_pkg::NumW-1:0] f_nl, f_nr;
  logic [ddwr_pkg::DenW-1:0] f_den;
  logic [1:0] f_dir;
  logic d_vld;
  logic signed [ddwr_pkg::Quo0W:0] d_left, d_right;
  logic [1:0] d_dir;
  logic s1_vld, s2_vld;
  logic signed [VW-1:0] s1_left, s1_right, s2_left, s2_right;
  logic [1:0] s1_dir, s2_dir;
  logic swap;
  logic signed [VW-1:0] fin_l, fin_r;

  // Global advance: the output register is free or its transfer completes.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diameter_q <= ddwr_pkg::RST_WHEEL_DIAMETER;
      track_q    <= ddwr_pkg::RST_TRACK_WIDTH;
      gear_q     <= ddwr_pkg::RST_GEAR_RATIO;
      max_q      <= ddwr_pkg::RST_MAX_RPM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddwr_pkg::CFG_WHEEL_DIAMETER: diameter_q <= cfg_wdata_i;
        ddwr_pkg::CFG_TRACK_WIDTH:    track_q    <= cfg_wdata_i;
        ddwr_pkg::CFG_GEAR_RATIO:     gear_q     <= cfg_wdata_i;
        ddwr_pkg::CFG_MAX_RPM:        max_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ddwr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .lin_i      ($signed(s_axis_tdata[15:0])),
    .ang_i      ($signed(s_axis_tdata[31:16])),
    .dir_i      (s_axis_tdata[33:32]),
    .diameter_i (diameter_q),
    .track_i    (track_q),
    .gear_i     (gear_q),
    .valid_o    (f_vld),
    .num_l_o    (f_nl),
    .num_r_o    (f_nr),
    .den_o      (f_den),
    .dir_o      (f_dir)
  );

  // Side RPM divisions, left and right in lockstep.
  ddwr_div #(
    .NW (ddwr_pkg::NumW),
    .DW (ddwr_pkg::DenW),
    .QW (ddwr_pkg::Quo0W),
    .SW (2)
  ) u_div_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .num_i   (f_nl),
    .den_i   (f_den),
    .side_i  (f_dir),
    .valid_o (d_vld),
    .quo_o   (d_left),
    .side_o  (d_dir)
  );

  ddwr_div #(
    .NW (ddwr_pkg::NumW),
    .DW (ddwr_pkg::DenW),
    .QW (ddwr_pkg::Quo0W),
    .SW (2)
  ) u_div_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .num_i   (f_nr),
    .den_i   (f_den),
    .side_i  (f_dir),
    .valid_o (),
    .quo_o   (d_right),
    .side_o  ()
  );

  // Left overspeed check first, then right.
  ddwr_scale u_scale_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .trip_i  (VW'(d_left)),
    .other_i (VW'(d_right)),
    .dir_i   (d_dir),
    .max_i   (max_q),
    .valid_o (s1_vld),
    .trip_o  (s1_left),
    .other_o (s1_right),
    .dir_o   (s1_dir)
  );

  ddwr_scale u_scale_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_vld),
    .trip_i  (s1_right),
    .other_i (s1_left),
    .dir_i   (s1_dir),
    .max_i   (max_q),
    .valid_o (s2_vld),
    .trip_o  (s2_right),
    .other_o (s2_left),
    .dir_o   (s2_dir)
  );

  // Swap when the faster side disagrees with the requested curve.
  assign swap = ((s2_left > s2_right) && (s2_dir == ddwr_pkg::DIR_RIGHT)) ||
                ((s2_right > s2_left) && (s2_dir == ddwr_pkg::DIR_LEFT));
  assign fin_l = swap ? s2_right : s2_left;
  assign fin_r = swap ? s2_left : s2_right;

  // Output register with saturation to the result range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fin_l > ddwr_pkg::OUT_MAX) begin
        left_out_q <= ddwr_pkg::OUT_MAX[23:0];
      end else if (fin_l < ddwr_pkg::OUT_MIN) begin
        left_out_q <= ddwr_pkg::OUT_MIN[23:0];
      end else begin
        left_out_q <= fin_l[23:0];
      end
      if (fin_r > ddwr_pkg::OUT_MAX) begin
        right_out_q <= ddwr_pkg::OUT_MAX[23:0];
      end else if (fin_r < ddwr_pkg::OUT_MIN) begin
        right_out_q <= ddwr_pkg::OUT_MIN[23:0];
      end else begin
        right_out_q <= fin_r[23:0];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {right_out_q, left_out_q};

endmodule

[hw/rtl/ddwr_div.sv]
// Pipelined rounding divider: quotient = round(num / den), ties away from
// zero, one quotient bit resolved per register stage. den must be nonzero
// and |num| / den must stay below 2**QW.
module ddwr_div #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  input  logic        [SW-1:0] side_i,
  output logic                 valid_o,
  output logic signed [QW:0]   quo_o,
  output logic        [SW-1:0] side_o
);

  localparam int RW = ((NW > DW) ? NW : DW) + 1;
  localparam int TW = DW + 1 + QW;
  localparam int XW = (RW > TW) ? RW : TW;

  logic [RW-1:0] rem_q  [QW+1];
  logic [DW:0]   dd_q   [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          neg_q  [QW+1];
  logic          vld_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  logic [NW-1:0] mag;

  // Entry stage: rounding is folded in as (2|n| + d) / (2d).
  assign mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RW'({mag, 1'b0}) + RW'(den_i);
      dd_q[0]   <= {den_i, 1'b0};
      quo_q[0]  <= '0;
      neg_q[0]  <= num_i[NW-1];
      side_q[0] <= side_i;
    end
  end

  // One restoring subtract step per stage, most significant bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int SH = QW - k;
    logic [XW-1:0] trial;
    logic [XW-1:0] rem_w;
    logic          ge;

    assign trial = XW'(dd_q[k-1]) << SH;
    assign rem_w = XW'(rem_q[k-1]);
    assign ge    = (rem_w >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? RW'(rem_w - trial) : rem_q[k-1];
        dd_q[k]   <= dd_q[k-1];
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge};
        neg_q[k]  <= neg_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Restore the sign of the quotient.
  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign quo_o   = neg_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});

endmodule

[hw/rtl/ddwr_front.sv]
// Kinematics front end: forms both side numerators and the common
// denominator over three register stages.
module ddwr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [15:0]                   lin_i,
  input  logic signed [15:0]                   ang_i,
  input  logic        [1:0]                    dir_i,
  input  logic        [15:0]                   diameter_i,
  input  logic        [15:0]                   track_i,
  input  logic        [15:0]                   gear_i,
  output logic                                 valid_o,
  output logic signed [ddwr_pkg::NumW-1:0]     num_l_o,
  output logic signed [ddwr_pkg::NumW-1:0]     num_r_o,
  output logic        [ddwr_pkg::DenW-1:0]     den_o,
  output logic        [1:0]                    dir_o
);

  logic [2:0]        vld_q;
  logic [1:0]        dir1_q, dir2_q, dir3_q;
  logic signed [39:0] base_q;
  logic signed [32:0] tw_q;
  logic        [31:0] dg_q;
  logic signed [41:0] nl_q, nr_q;
  logic        [50:0] den2_q, den3_q;
  logic signed [ddwr_pkg::NumW-1:0] nl3_q, nr3_q;

  logic [15:0]        d_eff, g_eff;
  logic signed [40:0] turn;
  logic signed [51:0] nl375, nr375;

  // A zero diameter or gear ratio acts as one.
  assign d_eff = (diameter_i == 16'd0) ? 16'd1 : diameter_i;
  assign g_eff = (gear_i == 16'd0) ? 16'd1 : gear_i;

  assign turn  = tw_q * ddwr_pkg::K_TURN;
  assign nl375 = nl_q * ddwr_pkg::K_NUM;
  assign nr375 = nr_q * ddwr_pkg::K_NUM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage one: the three products of the inputs and registers.
      base_q <= lin_i * ddwr_pkg::K_BASE;
      tw_q   <= ang_i * $signed({1'b0, track_i});
      dg_q   <= d_eff * g_eff;
      dir1_q <= dir_i;
      // Stage two: side speeds and the denominator.
      nl_q   <= 42'(base_q) - 42'(turn);
      nr_q   <= 42'(base_q) + 42'(turn);
      den2_q <= dg_q * ddwr_pkg::K_DEN;
      dir2_q <= dir1_q;
      // Stage three: apply the RPM conversion factor.
      nl3_q  <= nl375[ddwr_pkg::NumW-1:0];
      nr3_q  <= nr375[ddwr_pkg::NumW-1:0];
      den3_q <= den2_q;
      dir3_q <= dir2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign num_l_o = nl3_q;
  assign num_r_o = nr3_q;
  assign den_o   = den3_q;
  assign dir_o   = dir3_q;

endmodule

[hw/rtl/ddwr_scale.sv]
// Overspeed limit for one side: when trip exceeds the maximum, trip becomes
// the maximum and other becomes round(other * max / trip).
module ddwr_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [ddwr_pkg::ValW-1:0]   trip_i,
  input  logic signed [ddwr_pkg::ValW-1:0]   other_i,
  input  logic        [1:0]                  dir_i,
  input  logic        [15:0]                 max_i,
  output logic                               valid_o,
  output logic signed [ddwr_pkg::ValW-1:0]   trip_o,
  output logic signed [ddwr_pkg::ValW-1:0]   other_o,
  output logic        [1:0]                  dir_o
);

  localparam int VW = ddwr_pkg::ValW;
  localparam int PW = VW + 16;
  localparam int SW = 2 + 1 + 2 * VW;

  logic                 vld_q;
  logic signed [PW-1:0] prod_q;
  logic [VW-2:0]        den_q;
  logic [SW-1:0]        side_q;
  logic                 out_vld_q;
  logic signed [VW-1:0] trip_q, other_q;
  logic [1:0]           dir_q;

  logic                 over;
  logic signed [PW:0]   prod;
  logic                 div_vld;
  logic signed [VW-1:0] div_quo;
  logic [SW-1:0]        div_side;
  logic                 s_over;
  logic signed [VW-1:0] s_trip, s_other;
  logic [1:0]           s_dir;

  // Multiply stage; the divider gets a harmless operand pair when not over.
  assign over = trip_i > $signed({{(VW-16){1'b0}}, max_i});
  assign prod = other_i * $signed({1'b0, max_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= valid_i;
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= over ? prod[PW-1:0] : '0;
      den_q  <= over ? trip_i[VW-2:0] : (VW-1)'(1);
      side_q <= {dir_i, over, trip_i, other_i};
    end
  end

  ddwr_div #(
    .NW (PW),
    .DW (VW - 1),
    .QW (VW - 1),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q),
    .num_i   (prod_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  assign {s_dir, s_over, s_trip, s_other} = div_side;

  // Select the limited or the original pair.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trip_q  <= s_over ? $signed({{(VW-16){1'b0}}, max_i}) : s_trip;
      other_q <= s_over ? div_quo : s_other;
      dir_q   <= s_dir;
    end
  end

  assign valid_o = out_vld_q;
  assign trip_o  = trip_q;
  assign other_o = other_q;
  assign dir_o   = dir_q;

endmodule
